@@ hdl/signed_binary_to_decimal_text_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the signed binary to decimal text block.
// Each macro checks an implication on the rising clock edge, ignored in reset.
// ---------------------------------------------------------------------------
`ifndef SIGNED_BINARY_TO_DECIMAL_TEXT_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_TEXT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define SBDT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbdt assertion failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define SBDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbdt assertion failed in the following cycle");

`else

`define SBDT_ASSERT_SAME(label, clk, rst, ante, cons)
`define SBDT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/sbdt_pkg.sv @@
// ---------------------------------------------------------------------------
// sbdt_pkg
// Widths, character codes and the BCD conversion step shared by the block.
// ---------------------------------------------------------------------------
package sbdt_pkg;

  // Width of the signed input value.
  localparam int VALUE_BITS = 32;

  // Number of decimal digits in the largest magnitude, two to the power of
  // VALUE_BITS minus one. Evaluated at elaboration only.
  function automatic int digit_count(input int bits);
    logic [63:0] v;
    int          n;
    v = 64'd1 << (bits - 1);
    n = 0;
    while (v != 64'd0) begin
      v = v / 64'd10;
      n++;
    end
    return n;
  endfunction

  localparam int MAX_DIGITS    = digit_count(VALUE_BITS);
  localparam int DIG_IDX_BITS  = $clog2(MAX_DIGITS);
  localparam int BCD_BITS      = 4 * MAX_DIGITS;

  // Double-dabble steps handled by each pipeline stage.
  localparam int STEP_BITS     = 4;
  localparam int DD_STAGES     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS      = DD_STAGES * STEP_BITS;

  // Result field widths.
  localparam int CHAR_BITS     = 6;
  localparam int TEXT_LEN_BITS = 4;

  // ASCII codes, cut to the result field width.
  localparam logic [CHAR_BITS-1:0] CH_MINUS = CHAR_BITS'(45);
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = CHAR_BITS'(48);

  typedef logic [MAX_DIGITS-1:0][3:0] bcd_t;
  typedef logic [DIG_IDX_BITS-1:0]    dig_idx_t;

  // Apply STEP_BITS double-dabble steps, taking the bits most significant
  // first: correct each digit of five or more by adding three, then shift.
  function automatic bcd_t dabble_bits(input bcd_t bcd_in,
                                       input logic [STEP_BITS-1:0] bits);
    bcd_t                b;
    logic [BCD_BITS-1:0] f;
    b = bcd_in;
    for (int s = STEP_BITS - 1; s >= 0; s--) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (b[d] >= 4'd5) begin
          b[d] = b[d] + 4'd3;
        end
      end
      f = b;
      f = {f[BCD_BITS-2:0], bits[s]};
      b = f;
    end
    return b;
  endfunction

endpackage

@@ hdl/signed_binary_to_decimal_text.sv @@
// A value taken on start passes the magnitude register, the double-dabble stages and the length stage.
// Throughput: one character per cycle; a value holds the output for its text length,
// 1 to 11 characters, set by the character serialiser at the end of the pipeline.
// The double-dabble pipeline stalls as a whole while the serialiser is full.
// Reset (rst, synchronous) clears all valid bits; no character strobes after it.
// The receiver cannot stall: each character is valid for exactly one cycle.
// ---------------------------------------------------------------------------
// signed_binary_to_decimal_text
// Converts a signed integer to its decimal ASCII text, sign first, one
// character per cycle, through a pipelined double-dabble converter.
// ---------------------------------------------------------------------------
`include "signed_binary_to_decimal_text_macros.svh"

module signed_binary_to_decimal_text (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  output logic                                      busy,
  input  logic signed [sbdt_pkg::VALUE_BITS-1:0]    value,
  output logic                                      char_valid,
  output logic        [sbdt_pkg::CHAR_BITS-1:0]     char_code,
  output logic        [sbdt_pkg::TEXT_LEN_BITS-1:0] text_length,
  output logic                                      last_char
);

  localparam int DDS = sbdt_pkg::DD_STAGES;

  // Pipeline stage registers: entry 0 holds the magnitude, the rest the
  // double-dabble stages. The last stage has no magnitude bits left.
  logic                               dd_valid [0:DDS];
  logic                               dd_neg   [0:DDS];
  logic [sbdt_pkg::PAD_BITS-1:0]      dd_mag   [0:DDS-1];
  sbdt_pkg::bcd_t                     dd_bcd   [0:DDS];
  sbdt_pkg::bcd_t                     bcd_next [1:DDS];

  // Length stage registers.
  logic                               len_valid;
  logic                               len_neg;
  sbdt_pkg::bcd_t                     len_bcd;
  sbdt_pkg::dig_idx_t                 len_top;
  logic [sbdt_pkg::TEXT_LEN_BITS-1:0] len_total;
  sbdt_pkg::dig_idx_t                 len_top_next;

  // Serialiser registers.
  logic                               active;
  logic                               sign_pending;
  sbdt_pkg::dig_idx_t                 idx;
  sbdt_pkg::bcd_t                     ser_bcd;
  logic [sbdt_pkg::TEXT_LEN_BITS-1:0] ser_len;

  logic                               ser_free;
  logic                               advance;
  logic                               in_neg;
  logic [sbdt_pkg::VALUE_BITS-1:0]    in_mag;

  // The serialiser can take a new value when idle or on its last character.
  assign ser_free = !active || (!sign_pending && (idx == '0));
  assign advance  = !len_valid || ser_free;
  assign busy     = !advance;

  // Sign and unsigned magnitude; the most negative value negates to itself,
  // which read unsigned is the exact magnitude.
  assign in_neg = value[sbdt_pkg::VALUE_BITS-1];
  assign in_mag = in_neg ? (~value + 1'b1) : value;

  // Double-dabble work for each stage.
  always_comb begin
    for (int s = 1; s <= DDS; s++) begin
      bcd_next[s] = sbdt_pkg::dabble_bits(
          dd_bcd[s-1],
          dd_mag[s-1][sbdt_pkg::PAD_BITS-1 -: sbdt_pkg::STEP_BITS]);
    end
  end

  // Conversion pipeline valid bits, moving together on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DDS; s++) begin
        dd_valid[s] <= 1'b0;
      end
      len_valid <= 1'b0;
    end else if (advance) begin
      dd_valid[0] <= start;
      for (int s = 1; s <= DDS; s++) begin
        dd_valid[s] <= dd_valid[s-1];
      end
      len_valid <= dd_valid[DDS];
    end
  end

  // Conversion pipeline payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      dd_neg[0] <= in_neg;
      dd_mag[0] <= sbdt_pkg::PAD_BITS'(in_mag);
      dd_bcd[0] <= '0;
      for (int s = 1; s <= DDS; s++) begin
        dd_neg[s] <= dd_neg[s-1];
        dd_bcd[s] <= bcd_next[s];
      end
      for (int s = 1; s < DDS; s++) begin
        dd_mag[s] <= dd_mag[s-1] << sbdt_pkg::STEP_BITS;
      end
      len_neg   <= dd_neg[DDS];
      len_bcd   <= dd_bcd[DDS];
      len_top   <= len_top_next;
      len_total <= sbdt_pkg::TEXT_LEN_BITS'(int'(len_top_next) + 1 + int'(dd_neg[DDS]));
    end
  end

  // Position of the leading non-zero digit; zero keeps a single digit.
  always_comb begin
    len_top_next = '0;
    for (int d = 0; d < sbdt_pkg::MAX_DIGITS; d++) begin
      if (dd_bcd[DDS][d] != 4'd0) begin
        len_top_next = sbdt_pkg::DIG_IDX_BITS'(d);
      end
    end
  end

  // Serialiser control: sign first, then digits from the leading one down.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (len_valid && ser_free) begin
      active <= 1'b1;
    end else if (ser_free) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (len_valid && ser_free) begin
      sign_pending <= len_neg;
      idx          <= len_top;
      ser_bcd      <= len_bcd;
      ser_len      <= len_total;
    end else if (active) begin
      if (sign_pending) begin
        sign_pending <= 1'b0;
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end

  // Output register: one character transaction per cycle while active.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      char_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    char_code   <= sign_pending ? sbdt_pkg::CH_MINUS
                                : sbdt_pkg::CH_ZERO + sbdt_pkg::CHAR_BITS'(ser_bcd[idx]);
    text_length <= ser_len;
    last_char   <= !sign_pending && (idx == '0);
  end

  // A minus sign never ends a run.
  `SBDT_ASSERT_SAME(a_sign_not_last, clk, rst,
                    char_valid && (char_code == sbdt_pkg::CH_MINUS), !last_char)

  // Every character is a minus sign or a decimal digit.
  `SBDT_ASSERT_SAME(a_char_range, clk, rst, char_valid,
                    (char_code == sbdt_pkg::CH_MINUS) ||
                    ((char_code >= sbdt_pkg::CH_ZERO) &&
                     (char_code <= sbdt_pkg::CH_ZERO + sbdt_pkg::CHAR_BITS'(9))))

  // A run of characters is unbroken until its last one.
  `SBDT_ASSERT_NEXT(a_run_unbroken, clk, rst, char_valid && !last_char, char_valid)

endmodule
